// File: rtl/quadrature_encoder_detent_decoder_macros.svh
// ----------------------------------------------------------------------------
// Quadrature encoder detent decoder assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_ENCODER_DETENT_DECODER_MACROS_SVH
`define QUADRATURE_ENCODER_DETENT_DECODER_MACROS_SVH
`ifndef SYNTH
// checked on every clock edge outside reset
`define QEDD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every clock edge, reset included
`define QEDD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define QEDD_ASSERT(lbl, prop, msg)
`define QEDD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/qedd_pkg.sv
// ----------------------------------------------------------------------------
// qedd_pkg
// Shared types, constants and the transition step table of the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qedd_pkg;

  localparam int unsigned ENCODER_COUNT_DEF = 8;

  localparam int unsigned EncW    = 3;
  localparam int unsigned PhaseW  = 2;
  localparam int unsigned CountW  = 8;
  localparam int unsigned ResW    = 7;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 7;

  localparam logic [ResW-1:0] ResolutionRst = ResW'(4);

  typedef enum logic [CfgAddrW-1:0] {
    RegResolution = 2'd0,
    RegRestMode   = 2'd1,
    RegRestPhase  = 2'd2,
    RegReverse    = 2'd3
  } cfg_reg_e;

  // per-encoder stored state
  typedef struct packed {
    logic [PhaseW-1:0]        phase;
    logic signed [CountW-1:0] count;
  } enc_state_t;

  // register file as seen by the update logic
  typedef struct packed {
    logic [ResW-1:0]   resolution;
    logic              rest_mode;
    logic [PhaseW-1:0] rest_phase;
    logic              reverse;
  } cfg_t;

  // {old phase, new phase} -> -1, 0, +1
  localparam logic signed [1:0] StepTable [16] = '{
    2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
    -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
  };

endpackage

// File: rtl/qedd_state.sv
// ----------------------------------------------------------------------------
// qedd_state
// Per-encoder phase and pulse count registers, one write and one read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qedd_state #(
  parameter int unsigned ENCODER_COUNT = qedd_pkg::ENCODER_COUNT_DEF,
  parameter int unsigned IdxW = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clr_i,     // clear all counts, phases kept
  input  logic                  wr_en_i,
  input  logic [IdxW-1:0]       wr_idx_i,
  input  qedd_pkg::enc_state_t  wr_st_i,
  input  logic [IdxW-1:0]       rd_idx_i,
  output qedd_pkg::enc_state_t  rd_st_o
);

  qedd_pkg::enc_state_t st_q [ENCODER_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENCODER_COUNT; i++) begin
        st_q[i] <= '0;
      end
    end else if (clr_i) begin
      for (int i = 0; i < ENCODER_COUNT; i++) begin
        st_q[i].count <= '0;
      end
    end else if (wr_en_i) begin
      st_q[wr_idx_i] <= wr_st_i;
    end
  end

  assign rd_st_o = st_q[rd_idx_i];

endmodule

// File: rtl/qedd_update.sv
// ----------------------------------------------------------------------------
// qedd_update
// Step lookup, count update and detent decision for one pin sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qedd_update (
  input  logic [qedd_pkg::PhaseW-1:0] phase_i,
  input  qedd_pkg::enc_state_t        st_i,
  input  qedd_pkg::cfg_t              cfg_i,
  output qedd_pkg::enc_state_t        st_o,
  output logic                        moved_o,     // phase changed
  output logic                        event_valid_o,
  output logic                        cw_o
);

  localparam int unsigned SumW = qedd_pkg::CountW + 1;

  logic [3:0]               code;
  logic signed [SumW-1:0]   step;
  logic signed [SumW-1:0]   sum;
  logic signed [SumW-1:0]   res_s;
  logic signed [SumW-1:0]   next;
  logic [qedd_pkg::ResW-1:0] res_eff;
  logic                     ge;
  logic                     le;
  logic                     hit;
  logic                     pos;
  logic                     neg;

  always_comb begin
    moved_o = (phase_i != st_i.phase);
    code    = {st_i.phase, phase_i};
    step    = SumW'(qedd_pkg::StepTable[code]);
    sum     = SumW'(st_i.count) + step;
    // zero resolution acts as one
    res_eff = (cfg_i.resolution == '0) ? qedd_pkg::ResW'(1) : cfg_i.resolution;
    res_s   = $signed({2'b00, res_eff});
    ge      = (sum >= res_s);
    le      = (sum <= -res_s);
    if (cfg_i.rest_mode) begin
      hit  = ge || le || (phase_i == cfg_i.rest_phase);
      pos  = hit && (sum > 0);
      neg  = hit && (sum < 0);
      next = hit ? '0 : sum;
    end else begin
      hit  = ge || le;
      pos  = ge;
      neg  = le;
      // count stays within +-resolution, so one subtract is the remainder
      if (ge) begin
        next = sum - res_s;
      end else if (le) begin
        next = sum + res_s;
      end else begin
        next = sum;
      end
    end
    st_o.phase    = phase_i;
    st_o.count    = qedd_pkg::CountW'(next);
    event_valid_o = moved_o && (pos || neg);
    cw_o          = event_valid_o && (neg ^ cfg_i.reverse);
  end

endmodule

// File: rtl/quadrature_encoder_detent_decoder.sv
// ----------------------------------------------------------------------------
// quadrature_encoder_detent_decoder
// Detent decoder for up to ENCODER_COUNT quadrature rotary encoders.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pin sample per word: encoder number, A level, B level.
//   m_axis returns exactly one word per sample: event flag, encoder number
//   and turn direction (direction is 0 when no detent is reported).
//   cfg_we_i/cfg_addr_i/cfg_wdata_i write resolution, rest mode enable,
//   rest phase and direction reversal; write them only while idle.
//   Writing resolution clears every pulse count, phases are kept.
// Pipeline: an accepted sample passes the input register, then the result
//   register, before it leaves on m_axis. Throughput: one word per cycle
//   while m_axis_tready is high; the per-encoder state is read and written
//   in the same cycle, so back-to-back samples of one encoder need no bypass.
// Reset: phases and counts zero, resolution 4, other registers zero, both
//   pipeline stages empty.
// Stall: while m_axis_tready is low the result register holds; the input
//   register still fills, after which s_axis_tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "quadrature_encoder_detent_decoder_macros.svh"

module quadrature_encoder_detent_decoder #(
  parameter int unsigned ENCODER_COUNT = qedd_pkg::ENCODER_COUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // sample stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [2:0] encoder_number, [3] phase_a,
                                                        // [4] phase_b, [7:5] zero
  // event stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // [0] event_valid, [3:1] event_encoder,
                                                        // [4] turn_clockwise, [7:5] zero
  // register write port
  input  logic                           cfg_we_i,
  input  logic [qedd_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [qedd_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  localparam int unsigned IdxW = (ENCODER_COUNT > 1) ? $clog2(ENCODER_COUNT) : 1;

  // --- register file --------------------------------------------------------
  qedd_pkg::cfg_t     cfg_q;
  qedd_pkg::cfg_reg_e cfg_sel;
  logic               clr_counts;

  assign cfg_sel    = qedd_pkg::cfg_reg_e'(cfg_addr_i);
  assign clr_counts = cfg_we_i && (cfg_sel == qedd_pkg::RegResolution);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.resolution <= qedd_pkg::ResolutionRst;
      cfg_q.rest_mode  <= 1'b0;
      cfg_q.rest_phase <= '0;
      cfg_q.reverse    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_sel)
        qedd_pkg::RegResolution: cfg_q.resolution <= cfg_wdata_i[qedd_pkg::ResW-1:0];
        qedd_pkg::RegRestMode:   cfg_q.rest_mode  <= cfg_wdata_i[0];
        qedd_pkg::RegRestPhase:  cfg_q.rest_phase <= cfg_wdata_i[qedd_pkg::PhaseW-1:0];
        qedd_pkg::RegReverse:    cfg_q.reverse    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // --- pipeline control -----------------------------------------------------
  logic in_v_q;
  logic out_v_q;
  logic out_adv;   // result register can take a new word
  logic upd_fire;  // input word moves into the result register
  logic in_fire;

  assign out_adv       = !out_v_q || m_axis_tready;
  assign upd_fire      = in_v_q && out_adv;
  assign s_axis_tready = !in_v_q || out_adv;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_v_q <= s_axis_tvalid;
      end
      if (out_adv) begin
        out_v_q <= in_v_q;
      end
    end
  end

  // --- input register -------------------------------------------------------
  logic [qedd_pkg::EncW-1:0]   in_enc_q;
  logic [qedd_pkg::PhaseW-1:0] in_phase_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_enc_q   <= s_axis_tdata[2:0];
      in_phase_q <= {s_axis_tdata[4], s_axis_tdata[3]};  // B is phase bit 1
    end
  end

  // --- state and update -----------------------------------------------------
  logic                  in_range;
  logic [IdxW-1:0]       idx;
  qedd_pkg::enc_state_t  rd_st;
  qedd_pkg::enc_state_t  wr_st;
  logic                  moved;
  logic                  ev_raw;
  logic                  cw_raw;
  logic                  wr_en;
  logic                  ev;
  logic                  cw;

  // out-of-range encoder numbers leave state alone and report nothing
  assign in_range = (int'(in_enc_q) < int'(ENCODER_COUNT));
  assign idx      = IdxW'(in_enc_q);
  assign wr_en    = upd_fire && in_range && moved;
  assign ev       = in_range && ev_raw;
  assign cw       = in_range && cw_raw;

  qedd_state #(
    .ENCODER_COUNT (ENCODER_COUNT),
    .IdxW          (IdxW)
  ) u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (clr_counts),
    .wr_en_i  (wr_en),
    .wr_idx_i (idx),
    .wr_st_i  (wr_st),
    .rd_idx_i (idx),
    .rd_st_o  (rd_st)
  );

  qedd_update u_update (
    .phase_i       (in_phase_q),
    .st_i          (rd_st),
    .cfg_i         (cfg_q),
    .st_o          (wr_st),
    .moved_o       (moved),
    .event_valid_o (ev_raw),
    .cw_o          (cw_raw)
  );

  // --- result register ------------------------------------------------------
  logic                      out_ev_q;
  logic [qedd_pkg::EncW-1:0] out_enc_q;
  logic                      out_cw_q;

  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      out_ev_q  <= ev;
      out_enc_q <= in_enc_q;
      out_cw_q  <= cw;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {3'b000, out_cw_q, out_enc_q, out_ev_q};

  // --- assertions -----------------------------------------------------------
  // a zero resolution acts as one, so the count is then always cleared
  `QEDD_ASSERT(a_cw_needs_event,
    out_v_q && !out_ev_q |-> !out_cw_q,
    "direction set without a detent event")
  `QEDD_ASSERT(a_count_bounded,
    wr_en && !cfg_q.rest_mode |-> (wr_st.count == '0) || (wr_st.count < $signed({1'b0, cfg_q.resolution})),
    "normal-mode count left at or above resolution")
  `QEDD_ASSERT(a_result_from_input,
    out_v_q && !$past(out_v_q) |-> $past(in_v_q),
    "result word appeared without an input word")
  `QEDD_ASSERT_ALWAYS(a_reset_empty,
    !rst_ni |-> !m_axis_tvalid,
    "result valid during reset")

endmodule
